@@ rtl/core/msc_pkg.sv @@
// Shared types, command and opcode codes for the MIPS subset core.
package msc_pkg;

	// Default halfword memory depth (a power of two)
	localparam int MEM_DEPTH_DEF = 4096;

	// Command codes carried in s_tuser
	localparam logic [1:0] CMD_WRITE    = 2'd0;
	localparam logic [1:0] CMD_READ     = 2'd1;
	localparam logic [1:0] CMD_STEP     = 2'd2;
	localparam logic [1:0] CMD_PC_CLEAR = 2'd3;

	// Primary opcodes
	localparam logic [5:0] OP_RTYPE = 6'd0;
	localparam logic [5:0] OP_J     = 6'd2;
	localparam logic [5:0] OP_BEQ   = 6'd4;
	localparam logic [5:0] OP_ADDI  = 6'd8;
	localparam logic [5:0] OP_LH    = 6'd33;
	localparam logic [5:0] OP_LW    = 6'd35;
	localparam logic [5:0] OP_SH    = 6'd41;
	localparam logic [5:0] OP_SW    = 6'd43;

	// R-type function codes
	localparam logic [5:0] FN_ADD = 6'd32;
	localparam logic [5:0] FN_SUB = 6'd34;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_READ_DONE,
		ST_PC_CLEAR,
		ST_FETCH_HI,
		ST_FETCH_LO,
		ST_DECODE,
		ST_EXEC,
		ST_MEM2,
		ST_MEM3
	} state_t;

	// Report whether an opcode is one the core executes
	function automatic logic op_known(input logic [5:0] op);
		return op inside {OP_RTYPE, OP_J, OP_BEQ, OP_ADDI, OP_LH, OP_LW, OP_SH, OP_SW};
	endfunction

	// First sequencer state of a command
	function automatic state_t start_state(input logic [1:0] cmd);
		state_t st;
		case (cmd)
			CMD_WRITE: st = ST_WRITE;
			CMD_READ:  st = ST_READ;
			CMD_STEP:  st = ST_FETCH_HI;
			default:   st = ST_PC_CLEAR;
		endcase
		return st;
	endfunction

endpackage

@@ rtl/core/mips_subset_core_unit.sv @@
// Top level of the MIPS subset core: command sequencer, register file and halfword memory.
//
// Usage: commands arrive on the s_ stream, one transfer per command; each command
// returns exactly one result transfer on the m_ stream, in order.
// s_tuser selects the command: write halfword, read halfword, step one instruction,
// clear the program counter. s_tdata carries the halfword address and write data.
// m_tdata returns read data, the program counter after the command and the fetched
// instruction word; m_tuser flags an unknown opcode met by a step.
// The single port of the halfword memory (one access a cycle, registered read) sets
// the states: ST_WRITE; ST_PC_CLEAR; ST_READ, ST_READ_DONE; for a step ST_FETCH_HI,
// ST_FETCH_LO, ST_DECODE, ST_EXEC, then ST_MEM2 for LH and SW, ST_MEM2 and ST_MEM3
// for LW. The result shows on m_tdata the cycle after the last state. A new command
// is taken in that state, so commands run back to back while the result register is
// free. When the receiver stalls, the finished result holds in the output register;
// the following command runs to its last cycle and waits there without side effects.
// Reset clears the program counter, the sequencer, the output valid and the register
// file valid bits (unwritten registers read as zero). Memory contents are undefined
// until written. MEM_DEPTH must be a power of two; indices wrap to it.
module mips_subset_core_unit
	import msc_pkg::*;
#(
	parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [11:0] address, [27:12] write_data, [31:28] zero
	input  logic [1:0]  s_tuser,  // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // [15:0] read_data, [47:16] program_counter, [79:48] instruction
	output logic [0:0]  m_tuser   // [0] bad_instruction
);

	localparam int AW = $clog2(MEM_DEPTH);

	state_t state_q, state_nx;

	// Command payload
	logic [11:0]   addr_q;
	logic [15:0]   wdata_q;
	logic [AW-1:0] cmd_idx;

	// Program counter and instruction
	logic [31:0]   pc_q, pc_nx;
	logic [AW-1:0] pc_idx;
	logic [15:0]   ir_hi_q;
	logic [31:0]   ir_w, ir_q;
	logic [AW-1:0] ea_q;
	logic [15:0]   ld_hi_q;

	// Halfword memory
	logic [15:0]   mem [MEM_DEPTH];
	logic [15:0]   mem_rd_q, mem_wd;
	logic [AW-1:0] mem_addr;
	logic          mem_we, mem_re;

	// Register file
	logic [31:0] rf [32];
	logic [31:0] rf_vld_q;
	logic [31:0] rs_data_q, rt_data_q;
	logic        rf_re, rf_we;
	logic [4:0]  rf_wa;
	logic [31:0] rf_wd;

	// Decode and execute
	logic [5:0]  op, fn;
	logic [4:0]  rs_idx, rt_idx, rd_idx;
	logic [31:0] imm_sx, rs_val, rt_val, ea;
	logic        ex_mem;

	// Handshake
	logic fin_state, out_free, adv, accept, finish;

	// Output register
	logic        m_tvalid_q;
	logic [15:0] rd_out_q;
	logic [31:0] pc_out_q, ir_out_q;
	logic        bad_out_q;

	assign cmd_idx = AW'(addr_q);
	assign pc_idx  = pc_q[AW-1:0];
	assign ir_w    = {ir_hi_q, mem_rd_q};

	assign op     = ir_q[31:26];
	assign rs_idx = ir_q[25:21];
	assign rt_idx = ir_q[20:16];
	assign rd_idx = ir_q[15:11];
	assign fn     = ir_q[5:0];
	assign imm_sx = {{16{ir_q[15]}}, ir_q[15:0]};
	assign rs_val = rf_vld_q[rs_idx] ? rs_data_q : 32'd0;
	assign rt_val = rf_vld_q[rt_idx] ? rt_data_q : 32'd0;
	assign ea     = rs_val + imm_sx;
	assign ex_mem = (op == OP_LH) || (op == OP_LW) || (op == OP_SW);

	// Find the last cycle of a command and whether it may complete
	always_comb begin
		fin_state = (state_q inside {ST_WRITE, ST_READ_DONE, ST_PC_CLEAR, ST_MEM3})
			|| (state_q == ST_EXEC && !ex_mem)
			|| (state_q == ST_MEM2 && op != OP_LW);
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign adv      = !fin_state || out_free;
	assign finish   = fin_state && out_free;
	assign s_tready = (state_q == ST_IDLE) || finish;
	assign accept   = s_tvalid && s_tready;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nx = start_state(s_tuser);
			end
			ST_READ:     state_nx = ST_READ_DONE;
			ST_FETCH_HI: state_nx = ST_FETCH_LO;
			ST_FETCH_LO: state_nx = ST_DECODE;
			ST_DECODE:   state_nx = ST_EXEC;
			ST_EXEC: begin
				if (ex_mem) state_nx = ST_MEM2;
			end
			ST_MEM2: begin
				if (op == OP_LW) state_nx = ST_MEM3;
			end
			default: state_nx = state_q;
		endcase
		if (finish) state_nx = accept ? start_state(s_tuser) : ST_IDLE;
	end

	// Memory, register file and PC controls per state
	always_comb begin
		mem_addr = '0;
		mem_wd   = '0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		rf_re    = 1'b0;
		rf_we    = 1'b0;
		rf_wa    = '0;
		rf_wd    = '0;
		pc_nx    = pc_q;
		case (state_q)
			ST_WRITE: begin
				mem_addr = cmd_idx;
				mem_wd   = wdata_q;
				mem_we   = out_free;
			end
			ST_READ: begin
				mem_addr = cmd_idx;
				mem_re   = 1'b1;
			end
			ST_PC_CLEAR: pc_nx = '0;
			ST_FETCH_HI: begin
				mem_addr = pc_idx;
				mem_re   = 1'b1;
			end
			ST_FETCH_LO: begin
				mem_addr = pc_idx + AW'(1);
				mem_re   = 1'b1;
			end
			ST_DECODE: begin
				rf_re = 1'b1;
				pc_nx = pc_q + 32'd2;
			end
			ST_EXEC: begin
				mem_addr = ea[AW-1:0];
				case (op)
					OP_RTYPE: begin
						rf_wa = rd_idx;
						if (fn == FN_ADD) begin
							rf_wd = rs_val + rt_val;
							rf_we = out_free;
						end else if (fn == FN_SUB) begin
							rf_wd = rs_val - rt_val;
							rf_we = out_free;
						end
					end
					OP_ADDI: begin
						rf_wa = rt_idx;
						rf_wd = ea;
						rf_we = out_free;
					end
					OP_LH, OP_LW: mem_re = 1'b1;
					OP_SH: begin
						mem_wd = rt_val[15:0];
						mem_we = out_free;
					end
					OP_SW: begin
						mem_wd = rt_val[31:16];
						mem_we = 1'b1;
					end
					OP_BEQ: begin
						if (rs_val == rt_val) pc_nx = pc_q + {imm_sx[30:0], 1'b0};
					end
					OP_J: pc_nx = {pc_q[31:28], 1'b0, ir_q[25:0], 1'b0};
					default: ;
				endcase
			end
			ST_MEM2: begin
				mem_addr = ea_q + AW'(1);
				case (op)
					OP_LW: mem_re = 1'b1;
					OP_SW: begin
						mem_wd = rt_val[15:0];
						mem_we = out_free;
					end
					default: begin
						rf_wa = rt_idx;
						rf_wd = {16'd0, mem_rd_q};
						rf_we = out_free;
					end
				endcase
			end
			ST_MEM3: begin
				rf_wa = rt_idx;
				rf_wd = {ld_hi_q, mem_rd_q};
				rf_we = out_free;
			end
			default: ;
		endcase
		// Drop writes to register zero
		if (rf_wa == 5'd0) rf_we = 1'b0;
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Program counter and register file valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			rf_vld_q <= '0;
		end else begin
			if (adv) pc_q <= pc_nx;
			if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
		end
	end

	// Capture command payload and intermediate values
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q  <= s_tdata[11:0];
			wdata_q <= s_tdata[27:12];
		end
		if (state_q == ST_FETCH_LO) ir_hi_q <= mem_rd_q;
		if (state_q == ST_DECODE) ir_q <= ir_w;
		if (state_q == ST_EXEC) ea_q <= ea[AW-1:0];
		if (state_q == ST_MEM2) ld_hi_q <= mem_rd_q;
	end

	// Halfword memory, one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wd;
		if (mem_re) mem_rd_q <= mem[mem_addr];
	end

	// Register file, one write and two registered reads
	always_ff @(posedge clk) begin
		if (rf_we) rf[rf_wa] <= rf_wd;
		if (rf_re) begin
			rs_data_q <= rf[ir_w[25:21]];
			rt_data_q <= rf[ir_w[20:16]];
		end
	end

	// Output valid: set on completion, clear on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (finish) begin
			rd_out_q  <= (state_q == ST_READ_DONE) ? mem_rd_q : 16'd0;
			pc_out_q  <= pc_nx;
			ir_out_q  <= (state_q inside {ST_EXEC, ST_MEM2, ST_MEM3}) ? ir_q : 32'd0;
			bad_out_q <= (state_q == ST_EXEC) && !op_known(op);
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = {ir_out_q, pc_out_q, rd_out_q};
	assign m_tuser[0] = bad_out_q;

endmodule

@@ rtl/core/msc_checker.sv @@
// Port-level checker for the MIPS subset core, bound to the top level.
module msc_checker
	import msc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,  // [11:0] address, [27:12] write_data, [31:28] zero
	input logic [1:0]  s_tuser,  // [1:0] command
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,  // [15:0] read_data, [47:16] program_counter, [79:48] instruction
	input logic [0:0]  m_tuser   // [0] bad_instruction
);

	logic out_known;

	// Decode the opcode of the returned instruction
	always_comb begin
		out_known = op_known(m_tdata[79:74]);
	end

	// Hold an offered command until its transfer
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("command changed while waiting");

	// Hold a stalled result
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Flag only opcodes the core does not execute
	a_bad_op: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !out_known)
		else $error("bad instruction flag on a known opcode");

	// A result with nonzero read data carries no instruction and no flag
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[15:0] != 16'd0) |-> (m_tdata[79:48] == 32'd0) && !m_tuser[0])
		else $error("read data mixed with step result");

endmodule

bind mips_subset_core_unit msc_checker u_msc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ dv/mips_core_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the MIPS subset core: predicts every command and compares result transfers.
module mips_core_checker
	import msc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // [11:0] address, [27:12] write_data, [31:28] zero
	input  logic [1:0]  s_tuser,  // [1:0] command
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,  // [15:0] read_data, [47:16] program_counter, [79:48] instruction
	input  logic [0:0]  m_tuser,  // [0] bad_instruction
	output int          errors,
	output int          outstanding
);

	localparam int ADDR_W = $clog2(MEM_DEPTH_DEF);

	typedef struct packed {
		logic [15:0] read_data;
		logic [31:0] pc;
		logic [31:0] instr;
		logic        bad;
	} core_result_t;

	// Shadow copy of the core state
	logic [31:0]  pc_shadow;
	logic [31:0]  gpr_shadow [32];
	logic [15:0]  mem_shadow [MEM_DEPTH_DEF];

	core_result_t pending_results [$];
	core_result_t oldest;
	int           mismatches = 0;

	assign errors = mismatches;

	// Memory indices wrap to the memory depth
	function automatic logic [15:0] mem_get(input logic [31:0] a);
		return mem_shadow[a[ADDR_W-1:0]];
	endfunction

	function automatic void mem_put(input logic [31:0] a, input logic [15:0] v);
		mem_shadow[a[ADDR_W-1:0]] = v;
	endfunction

	// Drop writes to register zero
	function automatic void gpr_put(input logic [4:0] r, input logic [31:0] v);
		if (r != 5'd0)
			gpr_shadow[r] = v;
	endfunction

	// Execute one instruction word; return 1 on an unknown opcode
	function automatic logic execute_instr(input logic [31:0] ir);
		logic [5:0]  op;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [5:0]  fn;
		logic [31:0] imm;
		logic [31:0] ea;
		logic        bad;
		op  = ir[31:26];
		rs  = ir[25:21];
		rt  = ir[20:16];
		rd  = ir[15:11];
		fn  = ir[5:0];
		imm = {{16{ir[15]}}, ir[15:0]};
		ea  = gpr_shadow[rs] + imm;
		bad = 1'b0;
		case (op)
			OP_RTYPE: begin
				if (fn == FN_ADD)
					gpr_put(rd, gpr_shadow[rs] + gpr_shadow[rt]);
				else if (fn == FN_SUB)
					gpr_put(rd, gpr_shadow[rs] - gpr_shadow[rt]);
			end
			OP_ADDI: gpr_put(rt, ea);
			OP_LH:   gpr_put(rt, {16'h0000, mem_get(ea)});
			OP_LW:   gpr_put(rt, {mem_get(ea), mem_get(ea + 32'd1)});
			OP_SH:   mem_put(ea, gpr_shadow[rt][15:0]);
			OP_SW: begin
				mem_put(ea, gpr_shadow[rt][31:16]);
				mem_put(ea + 32'd1, gpr_shadow[rt][15:0]);
			end
			OP_BEQ: begin
				if (gpr_shadow[rs] == gpr_shadow[rt])
					pc_shadow = pc_shadow + (imm << 1);
			end
			OP_J:    pc_shadow = {pc_shadow[31:28], 1'b0, ir[25:0], 1'b0};
			default: bad = 1'b1;
		endcase
		return bad;
	endfunction

	// Apply one command to the shadow state and return its result
	function automatic core_result_t run_command(input logic [1:0] cmd, input logic [11:0] addr,
			input logic [15:0] wdata);
		core_result_t r;
		r = '0;
		case (cmd)
			CMD_WRITE: mem_put(32'(addr), wdata);
			CMD_READ:  r.read_data = mem_get(32'(addr));
			CMD_STEP: begin
				r.instr   = {mem_get(pc_shadow), mem_get(pc_shadow + 32'd1)};
				pc_shadow = pc_shadow + 32'd2;
				r.bad     = execute_instr(r.instr);
			end
			default:   pc_shadow = '0;
		endcase
		gpr_shadow[0] = '0;
		r.pc = pc_shadow;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			if (mismatches < 10)
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Compare result transfers first, then predict the command taken at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_shadow = '0;
			for (int i = 0; i < 32; i++)
				gpr_shadow[i] = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result transfer with no command pending", $time);
					mismatches++;
				end else begin
					oldest = pending_results.pop_front();
					check_field("read_data", 32'(oldest.read_data), 32'(m_tdata[15:0]));
					check_field("program_counter", oldest.pc, m_tdata[47:16]);
					check_field("instruction", oldest.instr, m_tdata[79:48]);
					check_field("bad_instruction", 32'(oldest.bad), 32'(m_tuser[0]));
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(run_command(s_tuser, s_tdata[11:0], s_tdata[27:12]));
			outstanding <= pending_results.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Top of the MIPS subset core testbench: clock, reset, command stimulus and verdict.
module testbench
	import msc_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS   = 410;

	// Memory layout: code space wraps from 4096-LOW_SPAN up to CODE_TOP-1,
	// data space runs from CODE_TOP to DATA_TOP-1; nothing else is ever read
	localparam int LOW_SPAN = 64;
	localparam int CODE_TOP = 256;
	localparam int DATA_TOP = 320;

	// Unknown opcode that fills unused code space
	localparam logic [5:0] OP_FILL = 6'd63;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [11:0] address, [27:12] write_data, [31:28] zero
	logic [1:0]  s_tuser;   // [1:0] command
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;   // [15:0] read_data, [47:16] program_counter, [79:48] instruction
	logic [0:0]  m_tuser;   // [0] bad_instruction

	int          errors;
	int          outstanding;
	int          sent = 0;
	int          idle_cycles = 0;
	bit          quiet = 1'b0;
	logic [31:0] demo_prog [16];

	always #5 clk = ~clk;

	mips_subset_core_unit #(
		.MEM_DEPTH(MEM_DEPTH_DEF)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	mips_core_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// Mostly short gaps, a few long ones; none at all in quiet stretches
	function automatic int pick_gap(input bit no_gaps);
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Favor low registers so results feed later instructions
	function automatic logic [4:0] pick_reg();
		if ($urandom_range(0, 2) != 0)
			return 5'($urandom_range(0, 7));
		return 5'($urandom);
	endfunction

	function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
			input logic [4:0] rd, input logic [5:0] fn);
		return {OP_RTYPE, rs, rt, rd, 5'($urandom), fn};
	endfunction

	function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
			input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] enc_j(input logic [25:0] target);
		return {OP_J, target};
	endfunction

	// Build one random instruction, mostly of known kinds; loads and stores
	// use register zero as base so they stay inside the preloaded spaces,
	// and branches and jumps keep the PC inside code space
	function automatic logic [31:0] rand_instr();
		int          kind;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [15:0] imm;
		logic [5:0]  op;
		logic [5:0]  fn;
		logic [31:0] ir;
		kind = $urandom_range(0, 19);
		rs   = pick_reg();
		rt   = pick_reg();
		rd   = pick_reg();
		imm  = 16'($urandom);
		case (kind)
			0, 1:   ir = enc_r(rs, rt, rd, FN_ADD);
			2, 3:   ir = enc_r(rs, rt, rd, FN_SUB);
			4: begin
				do fn = 6'($urandom_range(0, 63)); while (fn == FN_ADD || fn == FN_SUB);
				ir = enc_r(rs, rt, rd, fn);
			end
			5, 6, 7: ir = enc_i(OP_ADDI, rs, rt, imm);
			8, 9, 10, 11: begin
				imm = 16'($urandom_range(0, DATA_TOP + LOW_SPAN - 2)) - 16'(LOW_SPAN);
				ir  = enc_i((kind < 10) ? OP_LH : OP_LW, 5'd0, rt, imm);
			end
			12, 13, 14, 15: begin
				imm = 16'($urandom_range(CODE_TOP, DATA_TOP - 2));
				ir  = enc_i((kind < 14) ? OP_SH : OP_SW, 5'd0, rt, imm);
			end
			16, 17: begin
				if ($urandom_range(0, 1) != 0)
					rt = rs;
				imm = 16'($urandom_range(0, 8)) - 16'd3;
				ir = enc_i(OP_BEQ, rs, rt, imm);
			end
			18: ir = enc_j({15'($urandom), 11'($urandom_range(0, 47))});
			default: begin
				do op = 6'($urandom_range(0, 63)); while (op_known(op));
				ir = {op, 26'($urandom)};
			end
		endcase
		return ir;
	endfunction

	// Offer one command and hold it until the transfer
	task automatic send(input logic [1:0] cmd, input logic [11:0] addr, input logic [15:0] data);
		int gap;
		gap = pick_gap(quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0000, data, addr};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Write one instruction as two halfwords, high first
	task automatic load_instr(input logic [11:0] addr, input logic [31:0] ir);
		send(CMD_WRITE, addr, ir[31:16]);
		send(CMD_WRITE, addr + 12'd1, ir[15:0]);
	endtask

	// Receiver stalls
	initial begin
		int run;
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 9) == 0)
				run = $urandom_range(50, 200);
			else
				run = $urandom_range(1, 12);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = pick_gap(1'b0);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// End the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("mips_subset_core_unit regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int          n;
		int          stop;
		int          base;
		logic [31:0] ir;
		logic [1:0]  cmd;
		logic [11:0] addr;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = CMD_WRITE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Preload code space with unknown opcodes and data space with random
		// halfwords; no fetch or load ever leaves these two spaces
		quiet = 1'b1;
		for (int a = -LOW_SPAN; a < DATA_TOP; a++)
			send(CMD_WRITE, 12'(a),
				(a < CODE_TOP) ? {OP_FILL, 10'($urandom)} : 16'($urandom));
		quiet = 1'b0;

		// Directed program: every opcode, sign extension, r0 writes, wrap, branches, jump
		demo_prog = '{
			enc_i(OP_ADDI, 5'd0, 5'd1, 16'h7FFF),
			enc_i(OP_ADDI, 5'd0, 5'd2, 16'h8000),
			enc_r(5'd1, 5'd2, 5'd3, FN_ADD),
			enc_r(5'd2, 5'd1, 5'd4, FN_SUB),
			enc_r(5'd1, 5'd1, 5'd0, FN_ADD),
			enc_r(5'd1, 5'd2, 5'd5, 6'd63),
			enc_i(OP_SW, 5'd0, 5'd2, 16'hFFFF),
			enc_i(OP_LW, 5'd0, 5'd5, 16'hFFFF),
			enc_i(OP_SH, 5'd0, 5'd2, 16'd100),
			enc_i(OP_LH, 5'd0, 5'd6, 16'd100),
			enc_i(OP_BEQ, 5'd1, 5'd1, 16'd1),
			enc_r(5'd1, 5'd1, 5'd7, FN_ADD),
			enc_i(OP_BEQ, 5'd1, 5'd2, 16'd5),
			{6'd63, 26'h3FFFFFF},
			enc_i(OP_BEQ, 5'd0, 5'd0, 16'h8000),
			enc_j(26'h3FFFFFF)
		};
		for (int i = 0; i < 16; i++)
			load_instr(12'(2 * i), demo_prog[i]);
		repeat (16) send(CMD_STEP, 12'hFFF, 16'hFFFF);
		send(CMD_PC_CLEAR, 12'h000, 16'h0000);
		send(CMD_READ, 12'hFFF, 16'h0000);
		send(CMD_WRITE, 12'h000, 16'h0000);
		send(CMD_WRITE, 12'hFFF, 16'hFFFF);
		send(CMD_READ, 12'h000, 16'hFFFF);
		send(CMD_READ, 12'hFFF, 16'h0000);

		// Random part: mostly short programs run from a cleared PC, some raw commands
		stop = sent + RANDOM_ITEMS;
		while (sent < stop) begin
			quiet = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0) begin
				n = $urandom_range(2, 10);
				base = ($urandom_range(0, 2) == 0) ? 0 : 2 * $urandom_range(16, 40);
				if (base != 0)
					load_instr(12'h000, enc_j(26'(base / 2)));
				for (int i = 0; i < n; i++) begin
					ir = rand_instr();
					load_instr(12'(base + 2 * i), ir);
				end
				send(CMD_PC_CLEAR, 12'($urandom), 16'($urandom));
				repeat (n + (base != 0) + $urandom_range(0, 3))
					send(CMD_STEP, 12'($urandom), 16'($urandom));
			end else begin
				// Start from a cleared PC, then random commands; write only data space, read both spaces
				send(CMD_PC_CLEAR, 12'($urandom), 16'($urandom));
				repeat ($urandom_range(1, 6)) begin
					cmd = 2'($urandom);
					if (cmd == CMD_WRITE)
						addr = 12'($urandom_range(CODE_TOP, DATA_TOP - 1));
					else
						addr = 12'($urandom_range(0, DATA_TOP + LOW_SPAN - 1) - LOW_SPAN);
					send(cmd, addr, 16'($urandom));
				end
			end
		end
		quiet = 1'b0;

		// Drain and give the verdict
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("mips_subset_core_unit regression: pass");
		else
			$display("mips_subset_core_unit regression: fail");
		$finish;
	end

endmodule
